@@ rtl/core/aarm_pkg.sv @@
// Types, constants and the arctangent table shared by the rotation-matrix datapath.
package aarm_pkg;

   // Field and datapath widths
   localparam int FIELD_W      = 16;
   localparam int CORDIC_ITERS = 30;
   localparam int CORDIC_FRAC  = 30;
   localparam int ITER_IDX_W   = 5;
   localparam int CORDIC_W     = 33;                      // x, y in Q30 plus headroom
   localparam int ANGLE_W      = 32;                      // residual angle in binary turns
   localparam int T_W          = CORDIC_W + 1;            // t = 1 - c
   localparam int UV_W         = 2 * FIELD_W;             // axis component product
   localparam int HALF_W       = UV_W / 2;
   localparam int PLO_W        = T_W + HALF_W + 1;        // t * low half (unsigned)
   localparam int PHI_W        = T_W + HALF_W;            // t * high half (signed)
   localparam int PROD_W       = T_W + UV_W;              // full t * u * v
   localparam int SW_W         = CORDIC_W + FIELD_W;      // s * w

   // Gain-compensated 1.0 in Q30
   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;
   localparam logic signed [T_W-1:0]      ONE_Q30   = 34'sd1073741824;

   // Product index order
   localparam int P_XX = 0;
   localparam int P_YY = 1;
   localparam int P_ZZ = 2;
   localparam int P_XY = 3;
   localparam int P_XZ = 4;
   localparam int P_YZ = 5;
   localparam int NUM_PROD = 6;

   // s times axis index order
   localparam int S_X = 0;
   localparam int S_Y = 1;
   localparam int S_Z = 2;
   localparam int NUM_SW = 3;

   typedef struct packed {
      logic signed [FIELD_W-1:0] axis_x;
      logic signed [FIELD_W-1:0] axis_y;
      logic signed [FIELD_W-1:0] axis_z;
      logic        [FIELD_W-1:0] turn_angle;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] m00;
      logic signed [FIELD_W-1:0] m01;
      logic signed [FIELD_W-1:0] m02;
      logic signed [FIELD_W-1:0] m10;
      logic signed [FIELD_W-1:0] m11;
      logic signed [FIELD_W-1:0] m12;
      logic signed [FIELD_W-1:0] m20;
      logic signed [FIELD_W-1:0] m21;
      logic signed [FIELD_W-1:0] m22;
   } rsp_type;

   // atan(2^-i) in binary turns, 2^32 per full circle
   function automatic logic signed [ANGLE_W-1:0] atan_turn(input logic [ITER_IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      unique case (idx)
         5'd0:  val = 32'sd536870912;
         5'd1:  val = 32'sd316933406;
         5'd2:  val = 32'sd167458907;
         5'd3:  val = 32'sd85004756;
         5'd4:  val = 32'sd42667331;
         5'd5:  val = 32'sd21354465;
         5'd6:  val = 32'sd10679838;
         5'd7:  val = 32'sd5340245;
         5'd8:  val = 32'sd2670163;
         5'd9:  val = 32'sd1335087;
         5'd10: val = 32'sd667544;
         5'd11: val = 32'sd333772;
         5'd12: val = 32'sd166886;
         5'd13: val = 32'sd83443;
         5'd14: val = 32'sd41722;
         5'd15: val = 32'sd20861;
         5'd16: val = 32'sd10430;
         5'd17: val = 32'sd5215;
         5'd18: val = 32'sd2608;
         5'd19: val = 32'sd1304;
         5'd20: val = 32'sd652;
         5'd21: val = 32'sd326;
         5'd22: val = 32'sd163;
         5'd23: val = 32'sd81;
         5'd24: val = 32'sd41;
         5'd25: val = 32'sd20;
         5'd26: val = 32'sd10;
         5'd27: val = 32'sd5;
         5'd28: val = 32'sd3;
         5'd29: val = 32'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/core/axis_angle_rotation_matrix.sv @@
// Pipelined axis-angle (Rodrigues) rotation matrix: CORDIC sine/cosine and product tree.
//
//   channel   direction  payload                       handshake
//   req_      in         aarm_pkg::req_type (axis, angle)  req_valid / req_ready
//   rsp_      out        aarm_pkg::rsp_type (m00..m22)     rsp_valid / rsp_ready
//
// One request per cycle is accepted while req_ready is high; the path from acceptance to rsp_valid
// is one fold stage, 30 CORDIC stages, five product/sum stages and one output register.
// The whole pipeline advances on one enable that drops only while the skid register
// holds a result, so req_ready stays low for as long as the skid register is full.
// Synchronous reset clears every valid bit; payload registers are not reset.
module axis_angle_rotation_matrix #(
   parameter int FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  aarm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aarm_pkg::rsp_type rsp_data
);

   localparam int ITERS  = aarm_pkg::CORDIC_ITERS;
   localparam int CW     = aarm_pkg::CORDIC_W;
   localparam int AW     = aarm_pkg::ANGLE_W;
   localparam int TW     = aarm_pkg::T_W;
   localparam int FW     = aarm_pkg::FIELD_W;
   localparam int HW     = aarm_pkg::HALF_W;
   localparam int PW     = aarm_pkg::PROD_W;
   localparam int SWW    = aarm_pkg::SW_W;
   localparam int NP     = aarm_pkg::NUM_PROD;
   localparam int NS     = aarm_pkg::NUM_SW;
   // rounded term widths
   localparam int RW     = PW - 2 * FRAC_BITS;
   localparam int QW     = SWW - FRAC_BITS;
   localparam int MAX_A  = (CW > RW) ? CW : RW;
   localparam int MAX_B  = (MAX_A > QW) ? MAX_A : QW;
   localparam int SUM_W  = MAX_B + 2;
   localparam int OUT_SH = aarm_pkg::CORDIC_FRAC - FRAC_BITS;
   localparam int RV_W   = SUM_W - OUT_SH;
   localparam longint HI_L = (FRAC_BITS < FW - 1) ? (64'sd1 <<< FRAC_BITS) : 64'sd32767;
   localparam longint LO_L = (FRAC_BITS < FW - 1) ? -(64'sd1 <<< FRAC_BITS) : -64'sd32768;

   localparam logic signed [PW-1:0]    R_HALF   = PW'(1) <<< (2 * FRAC_BITS - 1);
   localparam logic signed [SWW-1:0]   Q_HALF   = SWW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] OUT_HALF = (SUM_W'(1) <<< OUT_SH) >>> 1;
   localparam logic signed [RV_W-1:0]  HI_LIM   = RV_W'(HI_L);
   localparam logic signed [RV_W-1:0]  LO_LIM   = RV_W'(LO_L);

   // round to output scale and saturate
   function automatic logic signed [FW-1:0] to_out(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] rnd;
      logic signed [RV_W-1:0]  rv;
      logic signed [RV_W-1:0]  cl;
      rnd = v + OUT_HALF;
      rv  = rnd[SUM_W-1:OUT_SH];
      if (rv > HI_LIM) begin
         cl = HI_LIM;
      end else if (rv < LO_LIM) begin
         cl = LO_LIM;
      end else begin
         cl = rv;
      end
      return cl[FW-1:0];
   endfunction

   logic en;
   logic skid_vld_ff, skid_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   aarm_pkg::rsp_type out_data, skid_ff, rsp_ff;

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   // ---------------- CORDIC section ----------------
   logic [ITERS:0]           cv_ff;
   logic signed [CW-1:0]     cx_ff [0:ITERS];
   logic signed [CW-1:0]     cy_ff [0:ITERS];
   logic signed [AW-1:0]     cz_ff [0:ITERS];
   logic                     flip_ff [0:ITERS];
   aarm_pkg::req_type        ax_ff [0:ITERS];
   logic signed [CW-1:0]     cx_in [1:ITERS];
   logic signed [CW-1:0]     cy_in [1:ITERS];
   logic signed [AW-1:0]     cz_in [1:ITERS];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
      end else if (en) begin
         cv_ff <= {cv_ff[ITERS-1:0], req_valid};
      end
   end

   // quadrant fold: second and third quadrants turn by a half circle and flip signs
   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]   <= aarm_pkg::CORDIC_X0;
         cy_ff[0]   <= '0;
         cz_ff[0]   <= {req_data.turn_angle[FW-2], req_data.turn_angle[FW-2:0],
                        (AW - FW)'(0)};
         flip_ff[0] <= req_data.turn_angle[FW-1] ^ req_data.turn_angle[FW-2];
         ax_ff[0]   <= req_data;
      end
   end

   for (genvar i = 0; i < ITERS; i++) begin : g_iter
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [AW-1:0] atn;

      // one micro-rotation
      always_comb begin
         dx  = cx_ff[i] >>> i;
         dy  = cy_ff[i] >>> i;
         atn = aarm_pkg::atan_turn((aarm_pkg::ITER_IDX_W)'(i));
         if (!cz_ff[i][AW-1]) begin
            cx_in[i+1] = cx_ff[i] - dy;
            cy_in[i+1] = cy_ff[i] + dx;
            cz_in[i+1] = cz_ff[i] - atn;
         end else begin
            cx_in[i+1] = cx_ff[i] + dy;
            cy_in[i+1] = cy_ff[i] - dx;
            cz_in[i+1] = cz_ff[i] + atn;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i+1]   <= cx_in[i+1];
            cy_ff[i+1]   <= cy_in[i+1];
            cz_ff[i+1]   <= cz_in[i+1];
            flip_ff[i+1] <= flip_ff[i];
            ax_ff[i+1]   <= ax_ff[i];
         end
      end
   end

   // ---------------- product section ----------------
   logic [5:1] pv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (en) begin
         pv_ff <= {pv_ff[4:1], cv_ff[ITERS]};
      end
   end

   // stage 1: signs, t = 1 - c, axis products
   logic signed [CW-1:0]  c1_in, s1_in, c1_ff, s1_ff;
   logic signed [TW-1:0]  t1_in, t1_ff;
   logic signed [2*FW-1:0] uv_in [NP];
   logic signed [2*FW-1:0] uv_ff [NP];
   aarm_pkg::req_type      ax1_ff;

   always_comb begin
      c1_in = flip_ff[ITERS] ? -cx_ff[ITERS] : cx_ff[ITERS];
      s1_in = flip_ff[ITERS] ? -cy_ff[ITERS] : cy_ff[ITERS];
      t1_in = aarm_pkg::ONE_Q30 - TW'(c1_in);
      uv_in[aarm_pkg::P_XX] = ax_ff[ITERS].axis_x * ax_ff[ITERS].axis_x;
      uv_in[aarm_pkg::P_YY] = ax_ff[ITERS].axis_y * ax_ff[ITERS].axis_y;
      uv_in[aarm_pkg::P_ZZ] = ax_ff[ITERS].axis_z * ax_ff[ITERS].axis_z;
      uv_in[aarm_pkg::P_XY] = ax_ff[ITERS].axis_x * ax_ff[ITERS].axis_y;
      uv_in[aarm_pkg::P_XZ] = ax_ff[ITERS].axis_x * ax_ff[ITERS].axis_z;
      uv_in[aarm_pkg::P_YZ] = ax_ff[ITERS].axis_y * ax_ff[ITERS].axis_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff  <= c1_in;
         s1_ff  <= s1_in;
         t1_ff  <= t1_in;
         uv_ff  <= uv_in;
         ax1_ff <= ax_ff[ITERS];
      end
   end

   // stage 2: t times each half of u*v, s times each axis component
   logic signed [aarm_pkg::PLO_W-1:0] plo_in [NP];
   logic signed [aarm_pkg::PLO_W-1:0] plo_ff [NP];
   logic signed [aarm_pkg::PHI_W-1:0] phi_in [NP];
   logic signed [aarm_pkg::PHI_W-1:0] phi_ff [NP];
   logic signed [SWW-1:0]             sw_in [NS];
   logic signed [SWW-1:0]             sw_ff [NS];
   logic signed [CW-1:0]              c2_ff;

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         plo_in[k] = t1_ff * $signed({1'b0, uv_ff[k][HW-1:0]});
         phi_in[k] = t1_ff * $signed(uv_ff[k][2*FW-1:HW]);
      end
      sw_in[aarm_pkg::S_X] = s1_ff * ax1_ff.axis_x;
      sw_in[aarm_pkg::S_Y] = s1_ff * ax1_ff.axis_y;
      sw_in[aarm_pkg::S_Z] = s1_ff * ax1_ff.axis_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         sw_ff  <= sw_in;
         c2_ff  <= c1_ff;
      end
   end

   // stage 3: join the partial products, round s terms to Q30
   logic signed [PW-1:0]  prod_in [NP];
   logic signed [PW-1:0]  prod_ff [NP];
   logic signed [SWW-1:0] swr [NS];
   logic signed [QW-1:0]  q_in [NS];
   logic signed [QW-1:0]  q3_ff [NS];
   logic signed [CW-1:0]  c3_ff;

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         prod_in[k] = (PW'(phi_ff[k]) <<< HW) + PW'(plo_ff[k]);
      end
      for (int k = 0; k < NS; k++) begin
         swr[k]  = sw_ff[k] + Q_HALF;
         q_in[k] = swr[k][SWW-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         q3_ff   <= q_in;
         c3_ff   <= c2_ff;
      end
   end

   // stage 4: round t*u*v terms to Q30
   logic signed [PW-1:0] prr [NP];
   logic signed [RW-1:0] r_in [NP];
   logic signed [RW-1:0] r4_ff [NP];
   logic signed [QW-1:0] q4_ff [NS];
   logic signed [CW-1:0] c4_ff;

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         prr[k]  = prod_ff[k] + R_HALF;
         r_in[k] = prr[k][PW-1:2*FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r4_ff <= r_in;
         q4_ff <= q3_ff;
         c4_ff <= c3_ff;
      end
   end

   // stage 5: matrix entry sums in Q30
   logic signed [SUM_W-1:0] sum_in [9];
   logic signed [SUM_W-1:0] sum_ff [9];

   always_comb begin
      sum_in[0] = SUM_W'(c4_ff) + SUM_W'(r4_ff[aarm_pkg::P_XX]);
      sum_in[1] = SUM_W'(r4_ff[aarm_pkg::P_XY]) - SUM_W'(q4_ff[aarm_pkg::S_Z]);
      sum_in[2] = SUM_W'(r4_ff[aarm_pkg::P_XZ]) + SUM_W'(q4_ff[aarm_pkg::S_Y]);
      sum_in[3] = SUM_W'(r4_ff[aarm_pkg::P_XY]) + SUM_W'(q4_ff[aarm_pkg::S_Z]);
      sum_in[4] = SUM_W'(c4_ff) + SUM_W'(r4_ff[aarm_pkg::P_YY]);
      sum_in[5] = SUM_W'(r4_ff[aarm_pkg::P_YZ]) - SUM_W'(q4_ff[aarm_pkg::S_X]);
      sum_in[6] = SUM_W'(r4_ff[aarm_pkg::P_XZ]) - SUM_W'(q4_ff[aarm_pkg::S_Y]);
      sum_in[7] = SUM_W'(r4_ff[aarm_pkg::P_YZ]) + SUM_W'(q4_ff[aarm_pkg::S_X]);
      sum_in[8] = SUM_W'(c4_ff) + SUM_W'(r4_ff[aarm_pkg::P_ZZ]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

   // final rounding and saturation
   always_comb begin
      out_data.m00 = to_out(sum_ff[0]);
      out_data.m01 = to_out(sum_ff[1]);
      out_data.m02 = to_out(sum_ff[2]);
      out_data.m10 = to_out(sum_ff[3]);
      out_data.m11 = to_out(sum_ff[4]);
      out_data.m12 = to_out(sum_ff[5]);
      out_data.m20 = to_out(sum_ff[6]);
      out_data.m21 = to_out(sum_ff[7]);
      out_data.m22 = to_out(sum_ff[8]);
   end

   // ---------------- output register and skid ----------------
   logic push;

   assign push        = en && pv_ff[5];
   assign rsp_vld_in  = (rsp_vld_ff && !rsp_ready) || skid_vld_ff || push;
   assign skid_vld_in = skid_vld_ff ? !rsp_ready : (push && rsp_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_ready) begin
            rsp_ff <= skid_ff;
         end
      end else if (push) begin
         if (!rsp_vld_ff || rsp_ready) begin
            rsp_ff <= out_data;
         end else begin
            skid_ff <= out_data;
         end
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ bench/tb_axis_angle_rotation_matrix.sv @@
// Self-checking bench for the Rodrigues rotation-matrix pipeline under random handshake pressure.
module tb_axis_angle_rotation_matrix;
   timeunit 1ns;
   timeprecision 1ps;

   typedef aarm_pkg::req_type request_type;
   typedef aarm_pkg::rsp_type matrix_type;

   localparam int FRAC_BITS    = 14;
   localparam int TRIG_FRAC    = 30;
   localparam int TRIG_STEPS   = 30;
   localparam longint TRIG_X0  = 64'sd652032874;  // gain-compensated 1.0, Q30
   localparam int RESET_CYCLES = 12;
   localparam int PHASE1_ITEMS = 500;
   localparam int PHASE2_ITEMS = 400;
   localparam int PHASE3_ITEMS = 630;
   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_TAIL   = 60;              // extra wait after the last result is checked
   localparam int STALL_LIMIT  = 2000;

   // atan(2^-i) in binary turns, 2^32 per circle
   localparam longint ATAN_TURNS [TRIG_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1
   };

   // axis x, y, z and angle for the directed requests
   localparam int DIRECTED_SET [20][4] = '{
      '{16384, 0, 0, 0},              '{0, 16384, 0, 16384},
      '{0, 0, 16384, 32768},          '{-16384, 0, 0, 49152},
      '{0, -16384, 0, 65535},         '{0, 0, -16384, 8192},
      '{9459, 9459, 9459, 21845},     '{11585, 11585, 0, 16383},
      '{11585, 0, -11585, 16385},     '{0, 11585, 11585, 32767},
      '{-11585, -11585, 0, 32769},    '{0, 0, 16384, 49151},
      '{0, 0, 16384, 49153},          '{32767, 32767, 32767, 12345},
      '{-32768, -32768, -32768, 40000}, '{-32768, 32767, 0, 32768},
      '{16384, 16384, 16384, 16384},  '{0, 0, 0, 24576},
      '{-16384, -16384, -16384, 57344}, '{16384, -16384, 16384, 1}
   };

   // Holds the expected matrices in request order and checks each result
   class rotation_scoreboard_type;
      matrix_type expected_matrices[$];
      int         errors;
      int         checked;

      // Round half up while dropping sh fraction bits (>>> floors)
      function longint round_off(longint v, int sh);
         return (v + (longint'(1) << (sh - 1))) >>> sh;
      endfunction

      // Sine and cosine in Q30, folding the second and third quadrants
      function void cordic_sincos(input logic [15:0] angle, output longint cs,
                                  output longint sn);
         logic [31:0] a;
         logic        flip;
         longint      x, y, z, dx, dy;
         a    = {angle, 16'h0000};
         flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
         if (flip) begin
            a = a + 32'h8000_0000;
         end
         z = longint'($signed(a));
         x = TRIG_X0;
         y = 0;
         for (int i = 0; i < TRIG_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - ATAN_TURNS[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + ATAN_TURNS[i];
            end
         end
         cs = flip ? -x : x;
         sn = flip ? -y : y;
      endfunction

      // base + t*u*v +/- s*w in Q30, rounded to Q1.14 and saturated
      function logic signed [15:0] matrix_entry(longint base, longint t, longint u,
                                                longint v, int sgn, longint s,
                                                longint w);
         longint lim, acc, q, r;
         lim = longint'(1) << FRAC_BITS;
         acc = base + round_off(t * (u * v), 2 * FRAC_BITS);
         if (sgn != 0) begin
            q   = round_off(s * w, FRAC_BITS);
            acc = (sgn > 0) ? acc + q : acc - q;
         end
         r = round_off(acc, TRIG_FRAC - FRAC_BITS);
         if (r > lim) r = lim;
         if (r < -lim) r = -lim;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return 16'(r);
      endfunction

      function matrix_type rodrigues_matrix(request_type req);
         matrix_type m;
         longint     x, y, z, c, s, t;
         x = longint'($signed(req.axis_x));
         y = longint'($signed(req.axis_y));
         z = longint'($signed(req.axis_z));
         cordic_sincos(req.turn_angle, c, s);
         t = (longint'(1) << TRIG_FRAC) - c;
         m.m00 = matrix_entry(c, t, x, x,  0, s, 0);
         m.m01 = matrix_entry(0, t, x, y, -1, s, z);
         m.m02 = matrix_entry(0, t, x, z,  1, s, y);
         m.m10 = matrix_entry(0, t, x, y,  1, s, z);
         m.m11 = matrix_entry(c, t, y, y,  0, s, 0);
         m.m12 = matrix_entry(0, t, y, z, -1, s, x);
         m.m20 = matrix_entry(0, t, x, z, -1, s, y);
         m.m21 = matrix_entry(0, t, y, z,  1, s, x);
         m.m22 = matrix_entry(c, t, z, z,  0, s, 0);
         return m;
      endfunction

      function void note_request(request_type req);
         expected_matrices.push_back(rodrigues_matrix(req));
      endfunction

      function void check_matrix(matrix_type got);
         string field_names [9] = '{"m00", "m01", "m02", "m10", "m11",
                                    "m12", "m20", "m21", "m22"};
         logic [$bits(matrix_type)-1:0] want_bits, got_bits;
         logic signed [15:0]            want_f, got_f;
         if (expected_matrices.size() == 0) begin
            $error("matrix result with no request outstanding");
            errors++;
            return;
         end
         want_bits = expected_matrices.pop_front();
         got_bits  = got;
         checked++;
         // m00 sits in the top 16 bits of the packed result
         for (int k = 0; k < 9; k++) begin
            want_f = want_bits[$bits(matrix_type)-1-16*k -: 16];
            got_f  = got_bits[$bits(matrix_type)-1-16*k -: 16];
            if (want_f !== got_f) begin
               $error("result %0d field %s: expected %0d, actual %0d",
                      checked, field_names[k], want_f, got_f);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_matrices.size();
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   request_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   matrix_type  rsp_data;

   rotation_scoreboard_type rot_sb = new;
   bit tx_idle_on   = 1'b0;
   bit rx_idle_on   = 1'b0;
   int hold_request = 0;
   int sent_count   = 0;

   always #1 clock = ~clock;

   axis_angle_rotation_matrix #(
      .FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Mostly near-unit axes, some arbitrary in-range, some full 16-bit noise
   function automatic request_type random_request();
      request_type r;
      int          pick, ax, ay, az, rem, ylim, rot;
      pick = $urandom_range(99);
      if (pick < 65) begin
         ax   = int'($urandom_range(32768)) - 16384;
         rem  = (1 << 28) - ax * ax;
         ylim = $rtoi($sqrt(real'(rem)));
         if (ylim * ylim > rem) ylim--;
         ay   = int'($urandom_range(2 * ylim)) - ylim;
         az   = $rtoi($sqrt(real'(rem - ay * ay)) + 0.5);
         if (az > 16384) az = 16384;
         if ($urandom_range(1) == 1) az = -az;
         rot  = $urandom_range(2);
         case (rot)
            0: begin
               r.axis_x = 16'(ax); r.axis_y = 16'(ay); r.axis_z = 16'(az);
            end
            1: begin
               r.axis_x = 16'(ay); r.axis_y = 16'(az); r.axis_z = 16'(ax);
            end
            default: begin
               r.axis_x = 16'(az); r.axis_y = 16'(ax); r.axis_z = 16'(ay);
            end
         endcase
      end else if (pick < 80) begin
         r.axis_x = 16'(int'($urandom_range(32768)) - 16384);
         r.axis_y = 16'(int'($urandom_range(32768)) - 16384);
         r.axis_z = 16'(int'($urandom_range(32768)) - 16384);
      end else begin
         r.axis_x = 16'($urandom);
         r.axis_y = 16'($urandom);
         r.axis_z = 16'($urandom);
      end
      // a quarter of the angles land near a quadrant boundary
      if ($urandom_range(3) == 0) begin
         r.turn_angle = 16'(($urandom_range(3) << 14) + $urandom_range(6) - 3);
      end else begin
         r.turn_angle = 16'($urandom);
      end
      return r;
   endfunction

   // Entered at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input request_type r);
      while (tx_idle_on && $urandom_range(99) < 30) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      rot_sb.note_request(r);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (rot_sb.pending() != 0) @(posedge clock);
   endtask

   // Result side: random back-pressure plus an occasional long hold-off
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = !rx_idle_on || ($urandom_range(99) >= 30);
         end
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            rot_sb.check_matrix(rsp_data);
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any handshake
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, rot_sb.pending());
      $display("*** FAILED ***");
      $finish;
   end

   // Request side and overall sequencing
   initial begin : request_side
      request_type r;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: axis extremes, every quadrant, wrap, non-unit axes
      for (int i = 0; i < 20; i++) begin
         r.axis_x     = 16'(DIRECTED_SET[i][0]);
         r.axis_y     = 16'(DIRECTED_SET[i][1]);
         r.axis_z     = 16'(DIRECTED_SET[i][2]);
         r.turn_angle = 16'(DIRECTED_SET[i][3]);
         send_request(r);
      end

      // random with idling on both sides
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (PHASE1_ITEMS) send_request(random_request());

      // sender pauses until the pipeline has emptied
      req_valid = 1'b0;
      wait_drained();
      @(negedge clock);

      // full rate, then a long receiver hold-off so the pipeline backs up
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      for (int i = 0; i < PHASE2_ITEMS; i++) begin
         if (i == HOLD_AT) hold_request = HOLD_CYCLES;
         send_request(random_request());
      end

      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (PHASE3_ITEMS) send_request(random_request());
      req_valid = 1'b0;

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("Sent %0d axis-angle requests (20 directed) and checked %0d matrices,",
               sent_count, rot_sb.checked);
      $display("with random stalls, a drain pause and a %0d-cycle receiver hold-off.",
               HOLD_CYCLES);
      if (rot_sb.errors == 0 && rot_sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
